>>> design/pwq_pkg.sv
package pwq_pkg;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_REM = 1'b1;

  typedef enum logic [2:0] {
    EV_QUEUED   = 3'd0,
    EV_GRANTED  = 3'd1,
    EV_RELEASED = 3'd2,
    EV_FULL     = 3'd3,
    EV_NOTFOUND = 3'd4
  } event_t;

  typedef struct packed {
    logic [7:0]  prio;
    logic [31:0] id;
  } entry_t;

  typedef struct packed {
    event_t      res;
    logic [31:0] id;
    logic        last;
  } result_t;

endpackage

>>> design/pwq_ram.sv
module pwq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/pwq_out_stage.sv
module pwq_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  output logic              res_ready,
  input  pwq_pkg::result_t  res,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,
  output logic [2:0]        out_tuser,
  output logic              out_tlast
);

  logic              valid_r;
  pwq_pkg::result_t  res_r;

  assign res_ready = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = res_r.id;
  assign out_tuser  = res_r.res;
  assign out_tlast  = res_r.last;

endmodule

>>> design/priority_work_queue_lock.sv
// Priority wait queue with one exclusive lock.
// in_*  : one request per handshake. in_tuser[0] = cmd (0 enqueue, 1 remove),
//         in_tdata = {priority_req, requester_id}.
// out_* : one event per handshake. out_tuser = event code, out_tdata = id,
//         out_tlast marks the final event of a request (one or two per request).
// The queue sits in a single RAM, kept sorted (lower priority value first,
// ties in arrival order). A small sequencer walks it one entry per cycle with
// a registered read and a write in the same cycle.
// Request handling, from accept to the first event offered:
//   enqueue: entries with a larger priority value shift toward the tail;
//            a full or lock-free enqueue goes straight to its events.
//   remove : scan to the match, then shift later entries down one per cycle;
//            when the holder leaves, the head is granted and the rest shift.
// One request is in flight at a time: in_tready is high only when idle.
// Events pass through a one-entry output register; while the receiver stalls
// the sequencer holds its next event, and a new request is taken only once
// the last event of the previous one sits in the output register.
// Reset (synchronous, rst_n low) empties the queue and frees the lock; no RAM
// clearing pass is needed, so the block is ready as soon as reset is released.
module priority_work_queue_lock #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // requester_id[31:0], priority_req[39:32]
  input  logic [0:0]  in_tuser,   // cmd[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // event_id[31:0]
  output logic [2:0]  out_tuser,  // event_res[2:0]
  output logic        out_tlast
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = $bits(pwq_pkg::entry_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ENQ_CMP,
    S_ENQ_WR,
    S_DEL_CMP,
    S_HOLD,
    S_GRANT,
    S_SHIFT,
    S_EMIT,
    S_EMIT2
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [31:0]       holder_id_r, holder_id_nxt;
  logic              holder_valid_r, holder_valid_nxt;
  logic [31:0]       req_id_r, req_id_nxt;
  logic [7:0]        req_prio_r, req_prio_nxt;
  pwq_pkg::event_t   r0_code_r, r0_code_nxt;
  logic              two_r, two_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  pwq_pkg::entry_t   ram_wdata;
  logic [EW-1:0]     ram_rdata;
  pwq_pkg::entry_t   rd;

  logic              res_valid, res_ready;
  pwq_pkg::result_t  res;

  assign rd        = pwq_pkg::entry_t'(ram_rdata);
  assign in_tready = (state_r == S_IDLE);

  pwq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pwq_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    pos_nxt          = pos_r;
    holder_id_nxt    = holder_id_r;
    holder_valid_nxt = holder_valid_r;
    req_id_nxt       = req_id_r;
    req_prio_nxt     = req_prio_r;
    r0_code_nxt      = r0_code_r;
    two_nxt          = two_r;
    ram_we           = 1'b0;
    ram_waddr        = pos_r;
    ram_wdata        = rd;
    ram_raddr        = '0;
    res_valid        = 1'b0;
    res.res          = r0_code_r;
    res.id           = req_id_r;
    res.last         = !two_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          req_id_nxt   = in_tdata[31:0];
          req_prio_nxt = in_tdata[39:32];
          if (in_tuser[0] == pwq_pkg::CMD_ENQ) begin
            if (cnt_r == CW'(QUEUE_DEPTH)) begin
              r0_code_nxt = pwq_pkg::EV_FULL;
              two_nxt     = 1'b0;
              state_nxt   = S_EMIT;
            end else if (!holder_valid_r) begin
              // lock free implies empty queue: the new requester takes the lock without entering the queue
              holder_id_nxt    = in_tdata[31:0];
              holder_valid_nxt = 1'b1;
              r0_code_nxt      = pwq_pkg::EV_QUEUED;
              two_nxt          = 1'b1;
              state_nxt        = S_EMIT;
            end else if (cnt_r == '0) begin
              pos_nxt   = '0;
              state_nxt = S_ENQ_WR;
            end else begin
              pos_nxt   = AW'(cnt_r);
              ram_raddr = AW'(cnt_r - CW'(1));
              state_nxt = S_ENQ_CMP;
            end
          end else begin
            if (cnt_r == '0) begin
              state_nxt = S_HOLD;
            end else begin
              pos_nxt   = '0;
              ram_raddr = '0;
              state_nxt = S_DEL_CMP;
            end
          end
        end
      end

      S_ENQ_CMP: begin
        ram_we = 1'b1;
        if (rd.prio > req_prio_r) begin
          ram_wdata = rd;
          pos_nxt   = pos_r - AW'(1);
          ram_raddr = pos_r - AW'(2);
          if (pos_r == AW'(1)) begin
            state_nxt = S_ENQ_WR;
          end
        end else begin
          ram_wdata.prio = req_prio_r;
          ram_wdata.id   = req_id_r;
          cnt_nxt        = cnt_r + CW'(1);
          r0_code_nxt    = pwq_pkg::EV_QUEUED;
          two_nxt        = 1'b0;
          state_nxt      = S_EMIT;
        end
      end

      S_ENQ_WR: begin
        ram_we         = 1'b1;
        ram_wdata.prio = req_prio_r;
        ram_wdata.id   = req_id_r;
        cnt_nxt        = cnt_r + CW'(1);
        r0_code_nxt    = pwq_pkg::EV_QUEUED;
        two_nxt        = 1'b0;
        state_nxt      = S_EMIT;
      end

      S_DEL_CMP: begin
        if (rd.id == req_id_r) begin
          r0_code_nxt = pwq_pkg::EV_RELEASED;
          two_nxt     = 1'b0;
          if (CW'(pos_r) + CW'(1) < cnt_r) begin
            ram_raddr = pos_r + AW'(1);
            state_nxt = S_SHIFT;
          end else begin
            cnt_nxt   = cnt_r - CW'(1);
            state_nxt = S_EMIT;
          end
        end else if (CW'(pos_r) + CW'(1) < cnt_r) begin
          pos_nxt   = pos_r + AW'(1);
          ram_raddr = pos_r + AW'(1);
        end else begin
          state_nxt = S_HOLD;
        end
      end

      S_HOLD: begin
        if (holder_valid_r && holder_id_r == req_id_r) begin
          holder_valid_nxt = 1'b0;
          holder_id_nxt    = '0;
          r0_code_nxt      = pwq_pkg::EV_RELEASED;
          if (cnt_r != '0) begin
            ram_raddr = '0;
            state_nxt = S_GRANT;
          end else begin
            two_nxt   = 1'b0;
            state_nxt = S_EMIT;
          end
        end else begin
          r0_code_nxt = pwq_pkg::EV_NOTFOUND;
          two_nxt     = 1'b0;
          state_nxt   = S_EMIT;
        end
      end

      S_GRANT: begin
        holder_id_nxt    = rd.id;
        holder_valid_nxt = 1'b1;
        two_nxt          = 1'b1;
        pos_nxt          = '0;
        if (cnt_r > CW'(1)) begin
          ram_raddr = AW'(1);
          state_nxt = S_SHIFT;
        end else begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_EMIT;
        end
      end

      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_wdata = rd;
        pos_nxt   = pos_r + AW'(1);
        if (CW'(pos_r) + CW'(2) < cnt_r) begin
          ram_raddr = pos_r + AW'(2);
        end else begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = two_r ? S_EMIT2 : S_IDLE;
        end
      end

      S_EMIT2: begin
        res_valid = 1'b1;
        res.res   = pwq_pkg::EV_GRANTED;
        res.id    = holder_id_r;
        res.last  = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      cnt_r          <= '0;
      holder_id_r    <= '0;
      holder_valid_r <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      cnt_r          <= cnt_nxt;
      holder_id_r    <= holder_id_nxt;
      holder_valid_r <= holder_valid_nxt;
    end
    pos_r      <= pos_nxt;
    req_id_r   <= req_id_nxt;
    req_prio_r <= req_prio_nxt;
    r0_code_r  <= r0_code_nxt;
    two_r      <= two_nxt;
  end

  // lock free only with an empty queue, except while the head is being granted
  a_free_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !holder_valid_r && state_r != S_GRANT |-> cnt_r == '0)
    else $error("queue not empty while lock free");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_grant_holder: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT2 |-> holder_valid_r)
    else $error("grant event without holder");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("new request taken while busy");

  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && res_ready && !two_r |=> state_r == S_IDLE)
    else $error("sequencer did not return to idle");

endmodule
